/* rtl/mmab_pkg.sv */
package mmab_pkg;

    // Default sizes, handed to the top level parameters
    localparam int MAX_DIM_DEF     = 8;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int RES_W   = 32;
    localparam int ACC_W   = 64;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 4;

    // Register reset values
    localparam logic [DIM_W-1:0] DIM_RST      = 4'd8;
    localparam logic             USE_BIAS_RST = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A    = 2'd0,
        KIND_LOAD_B    = 2'd1,
        KIND_LOAD_BIAS = 2'd2,
        KIND_START     = 2'd3
    } t_kind;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2,
        CFG_USE_BIAS  = 2'd3
    } t_cfg_reg;

    typedef logic signed [ACC_W-1:0] t_acc;

    // Control that travels with one multiply-accumulate slot
    typedef struct packed {
        logic             valid;
        logic             first;     // first term of an element
        logic             last_k;    // final term of an element
        logic             nop;       // empty inner dimension, product forced to zero
        logic             last_elem; // final element of the matrix
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_slot;

endpackage

/* rtl/matrix_multiply_add_bias_top.sv */
// Channel   | Dir | Handshake                     | Payload
// ----------+-----+-------------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: kind; tdata: row, col, elem_value
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: value, row, col; tlast: last
// cfg       | in  | i_cfg_we (no back-pressure)   | i_cfg_addr, i_cfg_data
//
// Load items (A, B, bias) each write one RAM entry when their indices are in range.
// A start item issues max(inner_dim,1) multiply-accumulate slots per result
// element (each size capped at MAX_DIM), one slot a cycle while the output is
// not stalled; one RAM read per store per slot sets this rate.
// Input is held off while slots are being issued.
// Reset (synchronous, active low) restores the size registers and the bias
// enable; the RAMs are not cleared. A stalled output freezes the whole read/multiply/accumulate pipe.
module matrix_multiply_add_bias_top #(
    parameter int MAX_DIM     = mmab_pkg::MAX_DIM_DEF,
    parameter int VALUE_WIDTH = mmab_pkg::VALUE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // tuser: kind [1:0]
    // tdata: row_index [2:0], col_index [5:3], elem_value [6+VALUE_WIDTH-1:6], zero pad
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [mmab_pkg::KIND_W-1:0]             s_axis_tuser,
    input  logic [((2*mmab_pkg::IDX_W+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,

    // tdata: result_value [31:0], result_row [34:32], result_col [37:35], zero pad
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((mmab_pkg::RES_W+2*mmab_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata,
    output logic                                    m_axis_tlast,

    input  logic                                    i_cfg_we,
    input  logic [mmab_pkg::CFG_A_W-1:0]            i_cfg_addr,
    input  logic [mmab_pkg::CFG_D_W-1:0]            i_cfg_data
);

    localparam int IDX_W   = mmab_pkg::IDX_W;
    localparam int DIM_W   = mmab_pkg::DIM_W;
    localparam int RES_W   = mmab_pkg::RES_W;
    localparam int OUT_W   = ((RES_W + 2*IDX_W + 7) / 8) * 8;
    localparam int AW      = $clog2(MAX_DIM * MAX_DIM);
    localparam int BW      = $clog2(MAX_DIM);
    localparam int FRAC    = VALUE_WIDTH / 2;
    localparam int PROD_W  = 2 * VALUE_WIDTH;
    localparam int DIM_CAP = (MAX_DIM > 15) ? 15 : MAX_DIM;

    localparam logic [DIM_W-1:0]   CAP      = DIM_CAP[DIM_W-1:0];
    localparam mmab_pkg::t_acc     ACC_HI   = 64'sd1 <<< 61;
    localparam mmab_pkg::t_acc     ACC_LO   = -(64'sd1 <<< 61);
    localparam mmab_pkg::t_acc     RES_HI   = 64'sd2147483647;
    localparam mmab_pkg::t_acc     RES_LO   = -64'sd2147483648;

    // ---------------------------------------------------------------- config
    logic [DIM_W-1:0] r_rows_a, r_inner_dim, r_cols_b;
    logic             r_use_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= mmab_pkg::DIM_RST;
            r_inner_dim <= mmab_pkg::DIM_RST;
            r_cols_b    <= mmab_pkg::DIM_RST;
            r_use_bias  <= mmab_pkg::USE_BIAS_RST;
        end else if (i_cfg_we) begin
            case (mmab_pkg::t_cfg_reg'(i_cfg_addr))
                mmab_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                mmab_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                mmab_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                mmab_pkg::CFG_USE_BIAS:  r_use_bias  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input
    mmab_pkg::t_kind        in_kind;
    logic [IDX_W-1:0]       in_row, in_col;
    logic [VALUE_WIDTH-1:0] in_val;
    logic                   in_acc;

    assign in_kind = mmab_pkg::t_kind'(s_axis_tuser);
    assign in_row  = s_axis_tdata[IDX_W-1:0];
    assign in_col  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_val  = s_axis_tdata[2*IDX_W+VALUE_WIDTH-1:2*IDX_W];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    logic          row_ok, col_ok;
    logic [31:0]   ld_addr_w, ld_bias_w;
    logic          we_a, we_b, we_bias, start;

    always_comb begin
        row_ok    = 32'(in_row) < MAX_DIM;
        col_ok    = 32'(in_col) < MAX_DIM;
        ld_addr_w = 32'(in_row) * MAX_DIM + 32'(in_col);
        ld_bias_w = 32'(in_col);
        we_a      = 1'b0;
        we_b      = 1'b0;
        we_bias   = 1'b0;
        start     = 1'b0;
        if (in_acc) begin
            case (in_kind)
                mmab_pkg::KIND_LOAD_A:    we_a    = row_ok && col_ok;
                mmab_pkg::KIND_LOAD_B:    we_b    = row_ok && col_ok;
                mmab_pkg::KIND_LOAD_BIAS: we_bias = col_ok;
                mmab_pkg::KIND_START:     start   = 1'b1;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- issue
    // adv moves every pipe stage, including the RAM read registers.
    logic adv;

    logic             r_busy;
    logic [DIM_W-1:0] r_i, r_j, r_k, r_nr, r_nk, r_nc;
    logic [DIM_W-1:0] nr_c, nk_c, nc_c;
    logic             k_last, j_last, i_last;
    logic [31:0]      rd_a_w, rd_b_w, rd_bias_w;
    mmab_pkg::t_slot  slot0;

    assign s_axis_tready = !r_busy;

    always_comb begin
        nr_c = (r_rows_a > CAP)    ? CAP : r_rows_a;
        nk_c = (r_inner_dim > CAP) ? CAP : r_inner_dim;
        nc_c = (r_cols_b > CAP)    ? CAP : r_cols_b;

        // an empty inner dimension still takes one slot to carry the bias
        k_last = (r_nk == '0) || (r_k == r_nk - 1'b1);
        j_last = (r_j == r_nc - 1'b1);
        i_last = (r_i == r_nr - 1'b1);

        rd_a_w    = 32'(r_i) * MAX_DIM + 32'(r_k);
        rd_b_w    = 32'(r_k) * MAX_DIM + 32'(r_j);
        rd_bias_w = 32'(r_j);

        slot0.valid     = r_busy;
        slot0.first     = (r_k == '0);
        slot0.last_k    = k_last;
        slot0.nop       = (r_nk == '0);
        slot0.last_elem = i_last && j_last;
        slot0.row       = r_i[IDX_W-1:0];
        slot0.col       = r_j[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (start) begin
            r_busy <= (nr_c != '0) && (nc_c != '0);
        end else if (r_busy && adv && k_last && j_last && i_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_i  <= '0;
            r_j  <= '0;
            r_k  <= '0;
            r_nr <= nr_c;
            r_nk <= nk_c;
            r_nc <= nc_c;
        end else if (r_busy && adv) begin
            if (k_last) begin
                r_k <= '0;
                if (j_last) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stores
    logic [VALUE_WIDTH-1:0] a_q, b_q, bias_q;

    mmab_ram #(.DATA_W(VALUE_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (ld_addr_w[AW-1:0]),
        .i_wdata (in_val),
        .i_re    (adv),
        .i_raddr (rd_a_w[AW-1:0]),
        .o_rdata (a_q)
    );

    mmab_ram #(.DATA_W(VALUE_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (ld_addr_w[AW-1:0]),
        .i_wdata (in_val),
        .i_re    (adv),
        .i_raddr (rd_b_w[AW-1:0]),
        .o_rdata (b_q)
    );

    mmab_ram #(.DATA_W(VALUE_WIDTH), .DEPTH(MAX_DIM)) u_ram_bias (
        .i_clk   (i_clk),
        .i_we    (we_bias),
        .i_waddr (ld_bias_w[BW-1:0]),
        .i_wdata (in_val),
        .i_re    (adv),
        .i_raddr (rd_bias_w[BW-1:0]),
        .o_rdata (bias_q)
    );

    // ---------------------------------------------------------------- stage 1: multiply
    mmab_pkg::t_slot           r_s1, r_s2, r_s3;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  prod_w;
    logic [VALUE_WIDTH-1:0]    r_bias;

    // signed operands, sign-extended to the product width
    assign prod_w = $signed(a_q) * $signed(b_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (adv) begin
            r_s1 <= slot0;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= r_s1.nop ? '0 : prod_w;
            r_bias <= bias_q;
        end
    end

    // ---------------------------------------------------------------- stage 2: accumulate
    mmab_pkg::t_acc r_acc;
    mmab_pkg::t_acc bias_ext, base, sum, n_acc;

    always_comb begin
        bias_ext = mmab_pkg::ACC_W'($signed(r_bias)) <<< FRAC;
        if (r_s2.first) begin
            base = r_use_bias ? bias_ext : '0;
        end else begin
            base = r_acc;
        end
        sum = base + mmab_pkg::ACC_W'(r_prod);
        if (sum > ACC_HI) begin
            n_acc = ACC_HI;
        end else if (sum < ACC_LO) begin
            n_acc = ACC_LO;
        end else begin
            n_acc = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2.valid) begin
            r_acc <= n_acc;
        end
    end

    // stage 3 marks a finished element; r_acc holds its sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else if (adv) begin
            r_s3       <= r_s2;
            r_s3.valid <= r_s2.valid && r_s2.last_k;
        end
    end

    // ---------------------------------------------------------------- output register
    logic               r_out_valid, r_out_last;
    logic [RES_W-1:0]   r_out_val;
    logic [IDX_W-1:0]   r_out_row, r_out_col;
    logic [RES_W-1:0]   sat_val;

    assign adv = !r_out_valid || m_axis_tready;

    always_comb begin
        if (r_acc > RES_HI) begin
            sat_val = RES_HI[RES_W-1:0];
        end else if (r_acc < RES_LO) begin
            sat_val = RES_LO[RES_W-1:0];
        end else begin
            sat_val = r_acc[RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s3.valid) begin
            r_out_val  <= sat_val;
            r_out_row  <= r_s3.row;
            r_out_col  <= r_s3.col;
            r_out_last <= r_s3.last_elem;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_W'({r_out_col, r_out_row, r_out_val});

endmodule

/* rtl/mmab_ram.sv */
module mmab_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
